### src/rra_pkg.sv
// ----------------------------------------------------------------------------
// rra_pkg
// shared widths, register indexes, pixel modes and pipeline sideband types
// for the rounded rectangle fill shader
// ----------------------------------------------------------------------------
package rra_pkg;

  localparam int COLOR_W    = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;
  localparam int SIZE_W     = 13;
  localparam int RADIUS_W   = 12;
  // signed rectangle edges, right and bottom edges reach 4095 + 8191
  localparam int EDGE_W     = 16;
  // doubled offset from arc centre inside a corner, |2*dx+1| < 8192
  localparam int OFS_W      = 15;
  // squared doubled distance, at most 2 * 8189^2
  localparam int DIST2_W    = 28;

  localparam logic [CFG_IDX_W-1:0] CFG_RECT_X         = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RECT_Y         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RECT_W         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_RECT_H         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CORNER_RADIUS  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_FILL_COLOR     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SURFACE_WIDTH  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SURFACE_HEIGHT = 3'd7;

  typedef enum logic [1:0] {
    MODE_KEEP,
    MODE_FILL,
    MODE_ARC
  } mode_t;

  typedef struct packed {
    logic signed [SIZE_W-1:0] rect_x;
    logic signed [SIZE_W-1:0] rect_y;
    logic [SIZE_W-1:0]        rect_w;
    logic [SIZE_W-1:0]        rect_h;
    logic [RADIUS_W-1:0]      corner_radius;
    logic [COLOR_W-1:0]       fill_color;
    logic [SIZE_W-1:0]        surface_width;
    logic [SIZE_W-1:0]        surface_height;
  } cfg_t;

  typedef struct packed {
    logic [RADIUS_W-1:0] radius;
    mode_t               mode;
    logic [COLOR_W-1:0]  dest;
  } side_t;

endpackage

### src/rounded_rect_aa_fill.sv
// ----------------------------------------------------------------------------
// rounded_rect_aa_fill
// per-pixel shader filling a rounded rectangle with antialiased corners
// ----------------------------------------------------------------------------
// Takes one pixel per clock and returns one result per pixel, in order. The
// pipeline is COVERAGE_FRAC_BITS + 22 register stages deep from an accepted
// request to out_valid: five geometry stages, one square root stage per root
// bit (COVERAGE_FRAC_BITS + 13 of them), three blend stages and the output
// register. With out_ready held high the throughput is one pixel per cycle;
// when the output stalls, a skid register takes one more result and in_ready
// then drops until the output drains. Configuration writes are taken every
// cycle and must only be made while no pixel is in flight.
module rounded_rect_aa_fill #(
  parameter int COORD_BITS         = 12,
  parameter int COVERAGE_FRAC_BITS = 8
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rra_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [rra_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [COORD_BITS-1:0]              pixel_x,
  input  logic [COORD_BITS-1:0]              pixel_y,
  input  logic [rra_pkg::COLOR_W-1:0]        dest_color,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [rra_pkg::COLOR_W-1:0]        out_color,
  output logic                               written
);

  localparam int RW     = rra_pkg::DIST2_W / 2 + COVERAGE_FRAC_BITS - 1;
  localparam int SIDE_W = $bits(rra_pkg::side_t);
  localparam int SZ     = rra_pkg::SIZE_W;

  rra_pkg::cfg_t cfg;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        rra_pkg::CFG_RECT_X:         cfg.rect_x         <= signed'(cfg_data[SZ-1:0]);
        rra_pkg::CFG_RECT_Y:         cfg.rect_y         <= signed'(cfg_data[SZ-1:0]);
        rra_pkg::CFG_RECT_W:         cfg.rect_w         <= cfg_data[SZ-1:0];
        rra_pkg::CFG_RECT_H:         cfg.rect_h         <= cfg_data[SZ-1:0];
        rra_pkg::CFG_CORNER_RADIUS:  cfg.corner_radius  <= cfg_data[rra_pkg::RADIUS_W-1:0];
        rra_pkg::CFG_FILL_COLOR:     cfg.fill_color     <= cfg_data[rra_pkg::COLOR_W-1:0];
        rra_pkg::CFG_SURFACE_WIDTH:  cfg.surface_width  <= cfg_data[SZ-1:0];
        rra_pkg::CFG_SURFACE_HEIGHT: cfg.surface_height <= cfg_data[SZ-1:0];
        default: ;
      endcase
    end
  end

  // the whole pipeline moves while the skid register is empty
  logic skid_valid;
  logic en;

  assign en       = !skid_valid;
  assign in_ready = en;

  logic                              g_valid;
  logic [rra_pkg::DIST2_W-1:0]       g_dist2;
  rra_pkg::side_t                    g_side;

  rra_geom #(
    .COORD_BITS (COORD_BITS)
  ) u_geom (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .cfg        (cfg),
    .pix_valid  (in_valid && in_ready),
    .pixel_x    (pixel_x),
    .pixel_y    (pixel_y),
    .dest_color (dest_color),
    .dist_valid (g_valid),
    .dist2      (g_dist2),
    .dist_side  (g_side)
  );

  logic                s_valid;
  logic [RW-1:0]       s_root;
  logic [SIDE_W-1:0]   s_side;

  rra_sqrt #(
    .DW     (rra_pkg::DIST2_W),
    .FRAC   (COVERAGE_FRAC_BITS),
    .SIDE_W (SIDE_W)
  ) u_sqrt (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .rad_valid  (g_valid),
    .radicand   (g_dist2),
    .rad_side   (g_side),
    .root_valid (s_valid),
    .root       (s_root),
    .root_side  (s_side)
  );

  logic                          b_valid;
  logic [rra_pkg::COLOR_W-1:0]   b_color;
  logic                          b_written;

  rra_blend #(
    .FRAC (COVERAGE_FRAC_BITS)
  ) u_blend (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .fill_color  (cfg.fill_color),
    .root_valid  (s_valid),
    .root        (s_root),
    .root_side   (rra_pkg::side_t'(s_side)),
    .res_valid   (b_valid),
    .res_color   (b_color),
    .res_written (b_written)
  );

  // output register with one skid entry behind it
  logic [rra_pkg::COLOR_W-1:0] skid_color;
  logic                        skid_written;
  logic                        take;

  assign take = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (b_valid) begin
      if (!out_valid || take) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        out_color <= skid_color;
        written   <= skid_written;
      end
    end else if (b_valid) begin
      if (!out_valid || take) begin
        out_color <= b_color;
        written   <= b_written;
      end else begin
        skid_color   <= b_color;
        skid_written <= b_written;
      end
    end
  end

endmodule

### src/rra_geom.sv
// ----------------------------------------------------------------------------
// rra_geom
// five stage front end: radius clamp, rectangle edges, pixel classification,
// squared offsets and squared distance to the arc centre
// ----------------------------------------------------------------------------
module rra_geom #(
  parameter int COORD_BITS = 12
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  rra_pkg::cfg_t                 cfg,
  input  logic                          pix_valid,
  input  logic [COORD_BITS-1:0]         pixel_x,
  input  logic [COORD_BITS-1:0]         pixel_y,
  input  logic [rra_pkg::COLOR_W-1:0]   dest_color,
  output logic                          dist_valid,
  output logic [rra_pkg::DIST2_W-1:0]   dist2,
  output rra_pkg::side_t                dist_side
);

  localparam int EW = rra_pkg::EDGE_W;
  localparam int SW = (COORD_BITS > rra_pkg::SIZE_W) ? COORD_BITS : rra_pkg::SIZE_W;
  localparam int PW = (COORD_BITS + 1 > EW) ? COORD_BITS + 1 : EW;
  localparam int OW = rra_pkg::OFS_W;
  localparam int QW = rra_pkg::DIST2_W - 1;

  // stage 1: capture, clamp radius, surface clip
  logic                            v1;
  logic [COORD_BITS-1:0]           px1, py1;
  logic [rra_pkg::COLOR_W-1:0]     dest1;
  logic [rra_pkg::RADIUS_W-1:0]    r1;
  logic                            surf1;
  logic [rra_pkg::RADIUS_W-1:0]    r_a, r_b, half_w, half_h;

  assign half_w = cfg.rect_w[rra_pkg::SIZE_W-1:1];
  assign half_h = cfg.rect_h[rra_pkg::SIZE_W-1:1];
  assign r_a    = (cfg.corner_radius < half_w) ? cfg.corner_radius : half_w;
  assign r_b    = (r_a < half_h) ? r_a : half_h;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= pix_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px1   <= pixel_x;
      py1   <= pixel_y;
      dest1 <= dest_color;
      r1    <= r_b;
      surf1 <= (SW'(pixel_x) < SW'(cfg.surface_width)) &&
               (SW'(pixel_y) < SW'(cfg.surface_height));
    end
  end

  // stage 2: edges, plain and inset by the radius
  logic                            v2;
  logic [COORD_BITS-1:0]           px2, py2;
  logic [rra_pkg::COLOR_W-1:0]     dest2;
  logic [rra_pkg::RADIUS_W-1:0]    r2;
  logic                            surf2;
  logic signed [EW-1:0]            x0_2, x1_2, x0r_2, x1r_2;
  logic signed [EW-1:0]            y0_2, y1_2, y0r_2, y1r_2;
  logic signed [EW-1:0]            x0_c, x1_c, y0_c, y1_c, r_s;

  assign r_s  = signed'(EW'(r1));
  assign x0_c = EW'(cfg.rect_x);
  assign y0_c = EW'(cfg.rect_y);
  assign x1_c = x0_c + signed'(EW'(cfg.rect_w));
  assign y1_c = y0_c + signed'(EW'(cfg.rect_h));

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px2   <= px1;
      py2   <= py1;
      dest2 <= dest1;
      r2    <= r1;
      surf2 <= surf1;
      x0_2  <= x0_c;
      x1_2  <= x1_c;
      x0r_2 <= x0_c + r_s;
      x1r_2 <= x1_c - r_s;
      y0_2  <= y0_c;
      y1_2  <= y1_c;
      y0r_2 <= y0_c + r_s;
      y1r_2 <= y1_c - r_s;
    end
  end

  // stage 3: classify, pick the arc centre, doubled offsets
  logic                            v3;
  logic [rra_pkg::COLOR_W-1:0]     dest3;
  logic [rra_pkg::RADIUS_W-1:0]    r3;
  rra_pkg::mode_t                  mode3;
  logic signed [OW-1:0]            ex3, ey3;
  logic signed [PW-1:0]            pxs, pys, cx_c, cy_c, dx_c, dy_c;
  logic                            in_rect, band_x, band_y;
  rra_pkg::mode_t                  mode_c;

  assign pxs = signed'(PW'(px2));
  assign pys = signed'(PW'(py2));

  assign in_rect = surf2 &&
                   (pxs >= PW'(x0_2)) && (pxs < PW'(x1_2)) &&
                   (pys >= PW'(y0_2)) && (pys < PW'(y1_2));
  assign band_x  = (pxs >= PW'(x0r_2)) && (pxs < PW'(x1r_2));
  assign band_y  = (pys >= PW'(y0r_2)) && (pys < PW'(y1r_2));

  assign cx_c = (pxs < PW'(x0r_2)) ? PW'(x0r_2) : PW'(x1r_2);
  assign cy_c = (pys < PW'(y0r_2)) ? PW'(y0r_2) : PW'(y1r_2);
  // inside a corner the offset is small, so the low bits carry it exactly
  assign dx_c = pxs - cx_c;
  assign dy_c = pys - cy_c;

  always_comb begin
    if (!in_rect) begin
      mode_c = rra_pkg::MODE_KEEP;
    end else if (band_x || band_y) begin
      mode_c = rra_pkg::MODE_FILL;
    end else begin
      mode_c = rra_pkg::MODE_ARC;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en) begin
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dest3 <= dest2;
      r3    <= r2;
      mode3 <= mode_c;
      ex3   <= {dx_c[OW-2:0], 1'b1};
      ey3   <= {dy_c[OW-2:0], 1'b1};
    end
  end

  // stage 4: squares
  logic                            v4;
  logic [rra_pkg::COLOR_W-1:0]     dest4;
  logic [rra_pkg::RADIUS_W-1:0]    r4;
  rra_pkg::mode_t                  mode4;
  logic [QW-1:0]                   sqx4, sqy4;
  logic signed [2*OW-1:0]          prod_x, prod_y;

  assign prod_x = ex3 * ex3;
  assign prod_y = ey3 * ey3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v4 <= 1'b0;
    end else if (en) begin
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dest4 <= dest3;
      r4    <= r3;
      mode4 <= mode3;
      sqx4  <= prod_x[QW-1:0];
      sqy4  <= prod_y[QW-1:0];
    end
  end

  // stage 5: squared distance with two fraction bits
  always_ff @(posedge clk) begin
    if (rst) begin
      dist_valid <= 1'b0;
    end else if (en) begin
      dist_valid <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dist2            <= {1'b0, sqx4} + {1'b0, sqy4};
      dist_side.radius <= r4;
      dist_side.mode   <= mode4;
      dist_side.dest   <= dest4;
    end
  end

endmodule

### src/rra_sqrt.sv
// ----------------------------------------------------------------------------
// rra_sqrt
// pipelined restoring square root, one root bit per stage, of the radicand
// scaled by 4^(FRAC-1); a sideband word travels alongside
// ----------------------------------------------------------------------------
module rra_sqrt #(
  parameter int DW     = 28,
  parameter int FRAC   = 8,
  parameter int SIDE_W = 38
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            rad_valid,
  input  logic [DW-1:0]                   radicand,
  input  logic [SIDE_W-1:0]               rad_side,
  output logic                            root_valid,
  output logic [DW/2+FRAC-2:0]            root,
  output logic [SIDE_W-1:0]               root_side
);

  localparam int RW  = DW / 2 + FRAC - 1;
  localparam int RMW = RW + 2;

  logic              vld_q  [RW];
  logic [RW-1:0]     root_q [RW];
  logic [SIDE_W-1:0] side_q [RW];
  logic [DW-1:0]     rad_q  [RW-1];
  logic [RMW-1:0]    rem_q  [RW-1];

  for (genvar k = 0; k < RW; k++) begin : g_step
    logic              vld_s;
    logic [DW-1:0]     rad_s;
    logic [RMW-1:0]    rem_s;
    logic [RW-1:0]     root_s;
    logic [SIDE_W-1:0] side_s;
    logic [RMW-1:0]    cur, trial;
    logic              fit;

    if (k == 0) begin : g_first
      assign vld_s  = rad_valid;
      assign rad_s  = radicand;
      assign rem_s  = '0;
      assign root_s = '0;
      assign side_s = rad_side;
    end else begin : g_next
      assign vld_s  = vld_q[k-1];
      assign rad_s  = rad_q[k-1];
      assign rem_s  = rem_q[k-1];
      assign root_s = root_q[k-1];
      assign side_s = side_q[k-1];
    end

    // next two radicand bits drop into the partial remainder
    assign cur   = {rem_s[RMW-3:0], rad_s[DW-1:DW-2]};
    assign trial = {root_s, 2'b01};
    assign fit   = cur >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        vld_q[k] <= 1'b0;
      end else if (en) begin
        vld_q[k] <= vld_s;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root_q[k] <= {root_s[RW-2:0], fit};
        side_q[k] <= side_s;
      end
    end

    if (k < RW - 1) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          rad_q[k] <= {rad_s[DW-3:0], 2'b00};
          rem_q[k] <= fit ? (cur - trial) : cur;
        end
      end
    end
  end

  assign root_valid = vld_q[RW-1];
  assign root       = root_q[RW-1];
  assign root_side  = side_q[RW-1];

endmodule

### src/rra_blend.sv
// ----------------------------------------------------------------------------
// rra_blend
// three stage back end: coverage from radius and distance, channel products,
// rounding and final colour selection
// ----------------------------------------------------------------------------
module rra_blend #(
  parameter int FRAC = 8
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      en,
  input  logic [rra_pkg::COLOR_W-1:0]               fill_color,
  input  logic                                      root_valid,
  input  logic [rra_pkg::DIST2_W/2+FRAC-2:0]        root,
  input  rra_pkg::side_t                            root_side,
  output logic                                      res_valid,
  output logic [rra_pkg::COLOR_W-1:0]               res_color,
  output logic                                      res_written
);

  localparam int CVW = rra_pkg::RADIUS_W + FRAC + 3;
  localparam int PRW = 8 + FRAC;

  // stage 1: coverage = radius + 1/2 - distance
  logic                           v1;
  logic [FRAC-1:0]                cov1;
  logic [rra_pkg::COLOR_W-1:0]    dest1;
  rra_pkg::mode_t                 mode1;
  logic signed [CVW-1:0]          cov_c;
  logic [CVW-1:0]                 half_c;
  rra_pkg::mode_t                 mode_c;

  assign half_c = CVW'(1) << (FRAC - 1);
  assign cov_c  = CVW'({root_side.radius, {FRAC{1'b0}}}) + half_c - CVW'(root);

  always_comb begin
    mode_c = root_side.mode;
    if (root_side.mode == rra_pkg::MODE_ARC) begin
      if (cov_c[CVW-1] || (cov_c == '0)) begin
        mode_c = rra_pkg::MODE_KEEP;
      end else if (cov_c[CVW-2:FRAC] != '0) begin
        mode_c = rra_pkg::MODE_FILL;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= root_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      cov1  <= cov_c[FRAC-1:0];
      dest1 <= root_side.dest;
      mode1 <= mode_c;
    end
  end

  // stage 2: per channel products
  logic                           v2;
  logic [rra_pkg::COLOR_W-1:0]    dest2;
  rra_pkg::mode_t                 mode2;
  logic [PRW-1:0]                 pf2 [3];
  logic [PRW-1:0]                 pd2 [3];
  logic [FRAC-1:0]                inv_c;

  // one - cov, taken modulo one since cov is never zero for a pixel left in arc mode
  assign inv_c = '0 - cov1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en) begin
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dest2 <= dest1;
      mode2 <= mode1;
      for (int ch = 0; ch < 3; ch++) begin
        pf2[ch] <= PRW'(fill_color[8*ch +: 8]) * PRW'(cov1);
        pd2[ch] <= PRW'(dest1[8*ch +: 8]) * PRW'(inv_c);
      end
    end
  end

  // stage 3: round, shift and select
  logic [rra_pkg::COLOR_W-1:0]    blend_c;
  logic [PRW:0]                   sum_c [3];
  logic [rra_pkg::COLOR_W-1:0]    color_c;
  logic                           wr_c;

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum_c[ch] = {1'b0, pf2[ch]} + {1'b0, pd2[ch]} + ((PRW + 1)'(1) << (FRAC - 1));
      blend_c[8*ch +: 8] = sum_c[ch][FRAC +: 8];
    end
  end

  always_comb begin
    unique case (mode2)
      rra_pkg::MODE_FILL: begin
        color_c = fill_color;
        wr_c    = 1'b1;
      end
      rra_pkg::MODE_ARC: begin
        color_c = blend_c;
        wr_c    = 1'b1;
      end
      default: begin
        color_c = dest2;
        wr_c    = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (en) begin
      res_valid <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_color   <= color_c;
      res_written <= wr_c;
    end
  end

endmodule

### src/rra_checker.sv
// ----------------------------------------------------------------------------
// rra_checker
// port level checks on the output register and input back-pressure
// ----------------------------------------------------------------------------
module rra_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [rra_pkg::COLOR_W-1:0] out_color,
  input logic                        written
);

  // reset leaves no result pending and the input open
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("result pending or input closed after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_color) && $stable(written))
    else $error("stalled result changed or dropped");

  // the input only closes while a result is waiting at the output
  a_stall_has_result: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> out_valid)
    else $error("input closed with no result on offer");

  // back-pressure follows a refused result in the cycle before
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> $past(out_valid && !out_ready))
    else $error("input closed without a stalled output");

endmodule

bind rounded_rect_aa_fill rra_checker u_rra_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_color (out_color),
  .written   (written)
);
